// File: sv/ite_pkg.sv
// Shared constants and helper functions for the ISO-8601 timestamp to epoch core.
// Holds character codes, text slot limits and calendar constants.
// No dependencies; imported by iso_timestamp_to_epoch_core.
package ite_pkg;

    // Text storage limits.
    localparam int unsigned TEXT_KEEP = 25;
    localparam int unsigned MIN_LEN   = 19;
    localparam int unsigned CNT_W     = 5;

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Calendar constants of the days-from-civil conversion.
    localparam logic [31:0] DAY_SHIFT     = 32'd719468;
    localparam logic [31:0] DAYS_PER_ERA  = 32'd146097;
    localparam logic [31:0] SEC_PER_DAY   = 32'd86400;
    localparam logic [31:0] SEC_PER_HOUR  = 32'd3600;
    localparam logic [31:0] SEC_PER_MIN   = 32'd60;
    localparam logic [31:0] YEARS_PER_ERA = 32'd400;
    // Three whole eras added so the era division sees a positive value.
    localparam logic [31:0] ERA_BIAS_YRS  = 32'd1200;
    localparam logic [5:0]  ERA_BIAS      = 6'd3;
    // Quotient of 2^32 by 5, for month terms that wrap below zero.
    localparam logic [31:0] WRAP_DIV5     = 32'd858993459;
    // Reciprocal of 5 scaled by 2^18, exact for 16-bit dividends.
    localparam logic [31:0] RECIP5        = 32'd52429;
    // Reciprocal of 25 scaled by 2^10, exact for dividends below 700.
    localparam logic [15:0] RECIP25       = 16'd41;

    // Whitespace as the C library sees it: space, tab, LF, VT, FF, CR.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Reads a slot of up to four characters with atoi rules. txt[0] is the
    // first character of the slot; len gives how many characters take part.
    function automatic logic signed [14:0] parse_field(input logic [3:0][7:0] txt,
                                                       input logic [2:0] len);
        logic       lead;
        logic       stop;
        logic       neg;
        logic [13:0] v;
        logic [7:0] c;
        lead = 1'b1;
        stop = 1'b0;
        neg  = 1'b0;
        v    = '0;
        for (int i = 0; i < 4; i++) begin
            c = txt[i];
            if ((i < int'(len)) && !stop) begin
                if (lead && is_blank(c)) begin
                    lead = 1'b1;
                end else if (lead && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                    neg  = (c == CH_MINUS);
                    lead = 1'b0;
                end else if (is_digit(c)) begin
                    v    = 14'(v * 14'd10 + {10'd0, 4'(c - CH_ZERO)});
                    lead = 1'b0;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    // Floor division of a 16-bit value by 5 through its reciprocal.
    function automatic logic [13:0] div5(input logic [15:0] n);
        logic [31:0] p;
        p = {16'd0, n} * RECIP5;
        return p[31:18];
    endfunction

endpackage

// File: sv/iso_timestamp_to_epoch_core.sv
// ISO-8601 timestamp text to signed epoch seconds, one character per item.
// Keeps the first 25 characters, then converts them in a short pipeline.
// Depends on ite_pkg for constants, the field parser and the divide-by-5 helper.
//
//   channel  | ports                          | item
//   ---------+--------------------------------+-------------------------------------
//   input    | s_tvalid s_tready s_tdata s_tlast | one text character, tlast ends text
//   result   | m_tvalid m_tready m_tdata      | epoch seconds, one per text
//
// One character is taken per cycle while s_tready is high; a text of any length
// may follow the previous one directly. The result of a text passes through the
// eight-register conversion pipeline after its last character is taken.
// Reset (aresetn low, synchronous) clears the character count and all stage
// valid bits. A stalled result holds each stage only as far back as needed;
// the input is held off only once every stage down to the frame stage is full.
module iso_timestamp_to_epoch_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_char
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] epoch_seconds
);
    import ite_pkg::*;

    // Character store and count.
    logic [7:0]       store_reg [TEXT_KEEP];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             s_accept;

    // Frame stage: snapshot of a complete text.
    logic             frm_vld_reg;
    logic             frm_rdy;
    logic [7:0]       frm_chars_reg [TEXT_KEEP];
    logic [CNT_W-1:0] frm_cnt_reg;

    // Parse stage.
    logic                prs_vld_reg;
    logic                prs_rdy;
    logic signed [14:0]  prs_year_reg;
    logic signed [7:0]   prs_month_reg, prs_day_reg, prs_hour_reg, prs_min_reg, prs_sec_reg;
    logic signed [7:0]   prs_offh_reg, prs_offm_reg;
    logic                prs_offen_reg, prs_offplus_reg, prs_short_reg;

    // Era stage.
    logic                era_vld_reg;
    logic                era_rdy;
    logic signed [5:0]   era_era_reg;
    logic signed [14:0]  era_ypr_reg;
    logic signed [15:0]  era_sval_reg;
    logic signed [7:0]   era_day_reg;
    logic signed [21:0]  era_tail_reg;
    logic                era_short_reg;

    // Year-of-era stage.
    logic                yoe_vld_reg;
    logic                yoe_rdy;
    logic signed [5:0]   yoe_era_reg;
    logic [8:0]          yoe_yoe_reg;
    logic [31:0]         yoe_doy_reg;
    logic signed [21:0]  yoe_tail_reg;
    logic                yoe_short_reg;

    // Day-of-era stage.
    logic                doe_vld_reg;
    logic                doe_rdy;
    logic signed [5:0]   doe_era_reg;
    logic [31:0]         doe_doe_reg;
    logic signed [21:0]  doe_tail_reg;
    logic                doe_short_reg;

    // Day-count stage.
    logic                day_vld_reg;
    logic                day_rdy;
    logic signed [34:0]  day_days_reg;
    logic signed [21:0]  day_tail_reg;
    logic                day_short_reg;

    // Product stage.
    logic                prd_vld_reg;
    logic                prd_rdy;
    logic signed [63:0]  prd_secs_reg;
    logic signed [21:0]  prd_tail_reg;
    logic                prd_short_reg;

    // Output register.
    logic                out_vld_reg;
    logic                out_rdy;
    logic [63:0]         out_data_reg;

    // Ready chain: a stage loads when it is empty or its content moves on.
    assign out_rdy  = !out_vld_reg || m_tready;
    assign prd_rdy  = !prd_vld_reg || out_rdy;
    assign day_rdy  = !day_vld_reg || prd_rdy;
    assign doe_rdy  = !doe_vld_reg || day_rdy;
    assign yoe_rdy  = !yoe_vld_reg || doe_rdy;
    assign era_rdy  = !era_vld_reg || yoe_rdy;
    assign prs_rdy  = !prs_vld_reg || era_rdy;
    assign frm_rdy  = !frm_vld_reg || prs_rdy;
    assign s_tready = frm_rdy;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Character count saturates at the kept length and restarts after a text.
    always_comb begin
        cnt_next = cnt_reg;
        if (s_accept) begin
            if (s_tlast) begin
                cnt_next = '0;
            end else if (cnt_reg < CNT_W'(TEXT_KEEP)) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Store each kept character at its position in the text.
    always_ff @(posedge aclk) begin
        if (s_accept && (cnt_reg < CNT_W'(TEXT_KEEP))) begin
            store_reg[cnt_reg] <= s_tdata;
        end
    end

    // Frame snapshot on the last character, which is merged in directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frm_vld_reg <= 1'b0;
        end else if (frm_rdy) begin
            frm_vld_reg <= s_accept && s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            for (int i = 0; i < int'(TEXT_KEEP); i++) begin
                frm_chars_reg[i] <= (CNT_W'(i) == cnt_reg) ? s_tdata : store_reg[i];
            end
            frm_cnt_reg <= (cnt_reg < CNT_W'(TEXT_KEEP)) ? cnt_reg + CNT_W'(1)
                                                          : CNT_W'(TEXT_KEEP);
        end
    end

    // Parse stage: read every fixed slot with atoi rules.
    logic signed [14:0] f_year, f_month, f_day, f_hour, f_min, f_sec, f_offh, f_offm;
    always_comb begin
        f_year  = parse_field({frm_chars_reg[3], frm_chars_reg[2],
                               frm_chars_reg[1], frm_chars_reg[0]}, 3'd4);
        f_month = parse_field({16'd0, frm_chars_reg[6],  frm_chars_reg[5]},  3'd2);
        f_day   = parse_field({16'd0, frm_chars_reg[9],  frm_chars_reg[8]},  3'd2);
        f_hour  = parse_field({16'd0, frm_chars_reg[12], frm_chars_reg[11]}, 3'd2);
        f_min   = parse_field({16'd0, frm_chars_reg[15], frm_chars_reg[14]}, 3'd2);
        f_sec   = parse_field({16'd0, frm_chars_reg[18], frm_chars_reg[17]}, 3'd2);
        f_offh  = parse_field({16'd0, frm_chars_reg[21], frm_chars_reg[20]}, 3'd2);
        f_offm  = parse_field({16'd0, frm_chars_reg[24], frm_chars_reg[23]}, 3'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prs_vld_reg <= 1'b0;
        end else if (prs_rdy) begin
            prs_vld_reg <= frm_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prs_rdy && frm_vld_reg) begin
            prs_year_reg    <= f_year;
            prs_month_reg   <= f_month[7:0];
            prs_day_reg     <= f_day[7:0];
            prs_hour_reg    <= f_hour[7:0];
            prs_min_reg     <= f_min[7:0];
            prs_sec_reg     <= f_sec[7:0];
            prs_offh_reg    <= f_offh[7:0];
            prs_offm_reg    <= f_offm[7:0];
            prs_offen_reg   <= (frm_cnt_reg == CNT_W'(TEXT_KEEP)) &&
                               ((frm_chars_reg[19] == CH_PLUS) ||
                                (frm_chars_reg[19] == CH_MINUS));
            prs_offplus_reg <= (frm_chars_reg[19] == CH_PLUS);
            prs_short_reg   <= (frm_cnt_reg < CNT_W'(MIN_LEN));
        end
    end

    // Era stage: shift the year for months 0, 1 and 2, find the era,
    // form the month term and the time-of-day seconds with the zone offset.
    logic               e_early;
    logic signed [14:0] e_ypr;
    logic [13:0]        e_biased;
    logic [15:0]        e_q25;
    logic signed [5:0]  e_era;
    logic signed [31:0] e_sval;
    logic signed [31:0] e_hms;
    logic signed [31:0] e_off;
    logic signed [31:0] e_tail;
    always_comb begin
        e_early  = (prs_month_reg >= 8'sd0) && (prs_month_reg <= 8'sd2);
        e_ypr    = prs_year_reg - (e_early ? 15'sd1 : 15'sd0);
        e_biased = 14'(e_ypr + $signed(ERA_BIAS_YRS[14:0]));
        e_q25    = {6'd0, e_biased[13:4]} * RECIP25;
        e_era    = $signed(e_q25[15:10]) - $signed(ERA_BIAS);
        if (e_early) begin
            e_sval = 32'sd153 * (32'(prs_month_reg) + 32'sd9) + 32'sd2;
        end else begin
            e_sval = 32'sd153 * (32'(prs_month_reg) - 32'sd3) + 32'sd2;
        end
        e_hms  = 32'(prs_hour_reg) * $signed(SEC_PER_HOUR)
               + 32'(prs_min_reg) * $signed(SEC_PER_MIN) + 32'(prs_sec_reg);
        e_off  = 32'(prs_offh_reg) * $signed(SEC_PER_HOUR)
               + 32'(prs_offm_reg) * $signed(SEC_PER_MIN);
        if (!prs_offen_reg) begin
            e_tail = e_hms;
        end else if (prs_offplus_reg) begin
            e_tail = e_hms - e_off;
        end else begin
            e_tail = e_hms + e_off;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            era_vld_reg <= 1'b0;
        end else if (era_rdy) begin
            era_vld_reg <= prs_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (era_rdy && prs_vld_reg) begin
            era_era_reg   <= e_era;
            era_ypr_reg   <= e_ypr;
            era_sval_reg  <= e_sval[15:0];
            era_day_reg   <= prs_day_reg;
            era_tail_reg  <= e_tail[21:0];
            era_short_reg <= prs_short_reg;
        end
    end

    // Year-of-era and day-of-year; the month term wraps like 32-bit unsigned.
    logic signed [15:0] y_yoe;
    logic [31:0]        y_qa;
    logic [31:0]        y_doy;
    logic signed [15:0] y_neg;
    always_comb begin
        y_yoe = 16'(era_ypr_reg) - 16'(era_era_reg) * $signed(YEARS_PER_ERA[15:0]);
        y_neg = 16'sd3 - era_sval_reg;
        if (era_sval_reg >= 16'sd0) begin
            y_qa = {18'd0, div5(era_sval_reg)};
        end else begin
            y_qa = WRAP_DIV5 - {18'd0, div5(y_neg)};
        end
        y_doy = y_qa + {{24{era_day_reg[7]}}, era_day_reg} - 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yoe_vld_reg <= 1'b0;
        end else if (yoe_rdy) begin
            yoe_vld_reg <= era_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (yoe_rdy && era_vld_reg) begin
            yoe_era_reg   <= era_era_reg;
            yoe_yoe_reg   <= y_yoe[8:0];
            yoe_doy_reg   <= y_doy;
            yoe_tail_reg  <= era_tail_reg;
            yoe_short_reg <= era_short_reg;
        end
    end

    // Day of era, wrapping modulo 2^32.
    logic [1:0]  d_cent;
    logic [31:0] d_doe;
    always_comb begin
        if (yoe_yoe_reg >= 9'd300) begin
            d_cent = 2'd3;
        end else if (yoe_yoe_reg >= 9'd200) begin
            d_cent = 2'd2;
        end else if (yoe_yoe_reg >= 9'd100) begin
            d_cent = 2'd1;
        end else begin
            d_cent = 2'd0;
        end
        d_doe = {23'd0, yoe_yoe_reg} * 32'd365 + {25'd0, yoe_yoe_reg[8:2]}
              - {30'd0, d_cent} + yoe_doy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            doe_vld_reg <= 1'b0;
        end else if (doe_rdy) begin
            doe_vld_reg <= yoe_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (doe_rdy && yoe_vld_reg) begin
            doe_era_reg   <= yoe_era_reg;
            doe_doe_reg   <= d_doe;
            doe_tail_reg  <= yoe_tail_reg;
            doe_short_reg <= yoe_short_reg;
        end
    end

    // Days since the epoch.
    logic signed [34:0] n_days;
    always_comb begin
        n_days = 35'(doe_era_reg) * $signed({3'd0, DAYS_PER_ERA})
               + $signed({3'd0, doe_doe_reg}) - $signed({3'd0, DAY_SHIFT});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_vld_reg <= 1'b0;
        end else if (day_rdy) begin
            day_vld_reg <= doe_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (day_rdy && doe_vld_reg) begin
            day_days_reg  <= n_days;
            day_tail_reg  <= doe_tail_reg;
            day_short_reg <= doe_short_reg;
        end
    end

    // Seconds of the whole days.
    logic signed [63:0] p_secs;
    always_comb begin
        p_secs = 64'(day_days_reg) * $signed({32'd0, SEC_PER_DAY});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prd_vld_reg <= 1'b0;
        end else if (prd_rdy) begin
            prd_vld_reg <= day_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prd_rdy && day_vld_reg) begin
            prd_secs_reg  <= p_secs;
            prd_tail_reg  <= day_tail_reg;
            prd_short_reg <= day_short_reg;
        end
    end

    // Output register: add the time of day with the zone offset, or zero for a short text.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_rdy) begin
            out_vld_reg <= prd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && prd_vld_reg) begin
            out_data_reg <= prd_short_reg ? 64'd0
                                          : 64'(prd_secs_reg + 64'(prd_tail_reg));
        end
    end

    // The count never passes the kept length.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(TEXT_KEEP))
        else $error("character count above kept length");

    // A taken last character restarts the count.
    a_cnt_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (cnt_reg == '0))
        else $error("count not cleared after end of text");

    // A held frame always carries at least one character.
    a_frm_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_vld_reg |-> (frm_cnt_reg != '0))
        else $error("empty frame in pipeline");

    // Input back-pressure only comes from a full, blocked frame stage.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (frm_vld_reg && prs_vld_reg && !prs_rdy))
        else $error("input stalled without a blocked frame");

    // A new result follows a product that was waiting in the previous cycle.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(prd_vld_reg))
        else $error("result without a product");

endmodule

// File: verif/iso_timestamp_to_epoch_core_test.sv
// Self-checking testbench for iso_timestamp_to_epoch_core: timestamp texts go in one
// character per item and every epoch result is checked against an in-bench calendar model.
// Depends on ite_pkg and iso_timestamp_to_epoch_core only.
`timescale 1ns / 1ps

module iso_timestamp_to_epoch_core_test;

    localparam int RANDOM_ITEMS = 1050;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PIPE_SETTLE  = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    // Characters of the text under way in the model, and the expected epochs.
    logic [7:0]  text_chars [ite_pkg::TEXT_KEEP];
    int unsigned text_len = 0;
    logic [63:0] epoch_expected_q [$];
    logic [7:0]  text_buf [$];

    int err_count   = 0;
    int chars_sent  = 0;
    int gap_max     = 13;
    int stall_max   = 13;
    int ready_hold  = 0;
    int idle_cycles = 0;

    iso_timestamp_to_epoch_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] text_char
        .s_tlast  (s_tlast),   // is_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [63:0] epoch_seconds
    );

    always #5 aclk = ~aclk;

    // C library whitespace: space, tab, LF, VT, FF, CR.
    function automatic logic is_white(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Reads one fixed slot with atoi rules; a slot past the kept text reads as 0.
    function automatic logic signed [31:0] slot_value(input int unsigned start,
                                                      input int unsigned len);
        int unsigned        i;
        int unsigned        stop;
        logic               neg;
        logic signed [31:0] v;
        i    = start;
        stop = start + len;
        neg  = 1'b0;
        v    = 0;
        if (stop > text_len) return 0;
        while (i < stop && is_white(text_chars[i])) i++;
        if (i < stop && (text_chars[i] == ite_pkg::CH_PLUS ||
                         text_chars[i] == ite_pkg::CH_MINUS)) begin
            neg = (text_chars[i] == ite_pkg::CH_MINUS);
            i++;
        end
        while (i < stop && text_chars[i] >= ite_pkg::CH_ZERO &&
               text_chars[i] <= ite_pkg::CH_NINE) begin
            v = v * 10 + $signed({24'd0, text_chars[i] - ite_pkg::CH_ZERO});
            i++;
        end
        return neg ? -v : v;
    endfunction

    // Converts the kept text to epoch seconds, with 32-bit wrap on the date terms.
    function automatic logic signed [63:0] text_to_epoch();
        logic signed [31:0] year;
        logic signed [31:0] month;
        logic signed [31:0] day;
        logic signed [31:0] hour;
        logic signed [31:0] minute;
        logic signed [31:0] second;
        logic signed [31:0] era;
        logic [31:0]        mon_u;
        logic [31:0]        day_u;
        logic [31:0]        yoe;
        logic [31:0]        adj;
        logic [31:0]        doy;
        logic [31:0]        doe;
        logic signed [63:0] days;
        logic signed [63:0] epoch;
        logic signed [63:0] off;
        if (text_len < ite_pkg::MIN_LEN) return 0;
        year   = slot_value(0, 4);
        month  = slot_value(5, 2);
        day    = slot_value(8, 2);
        hour   = slot_value(11, 2);
        minute = slot_value(14, 2);
        second = slot_value(17, 2);
        mon_u  = month;
        day_u  = day;
        if (mon_u <= 32'd2) year = year - 1;
        era  = ((year >= 0) ? year : year - 399) / 400;
        yoe  = year - era * 400;
        adj  = (mon_u > 32'd2) ? 32'hFFFF_FFFD : 32'd9;
        doy  = (32'd153 * (mon_u + adj) + 32'd2) / 32'd5 + day_u - 32'd1;
        doe  = yoe * 32'd365 + yoe / 32'd4 - yoe / 32'd100 + doy;
        days = era;
        days = days * 146097 + $signed({32'd0, doe}) - 719468;
        epoch = days * 86400;
        off   = hour;
        epoch = epoch + off * 3600;
        off   = minute;
        epoch = epoch + off * 60;
        off   = second;
        epoch = epoch + off;
        // Zone offset only on a full-length text with a sign at character 19.
        if (text_len >= ite_pkg::TEXT_KEEP && (text_chars[19] == ite_pkg::CH_PLUS ||
                                               text_chars[19] == ite_pkg::CH_MINUS)) begin
            off = slot_value(20, 2);
            off = off * 3600;
            days = slot_value(23, 2);
            off = off + days * 60;
            if (text_chars[19] == ite_pkg::CH_PLUS) epoch = epoch - off;
            else epoch = epoch + off;
        end
        return epoch;
    endfunction

    // Updates the model with one accepted character.
    function automatic void take_char(input logic [7:0] c, input logic last);
        if (text_len < ite_pkg::TEXT_KEEP) begin
            text_chars[text_len] = c;
            text_len++;
        end
        if (last) begin
            epoch_expected_q.insert(epoch_expected_q.size(), text_to_epoch());
            text_len = 0;
        end
    endfunction

    function automatic void load_text(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.insert(text_buf.size(), s[i]);
    endfunction

    // Sends one character after a random gap and waits until it is taken.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = $urandom_range(0, gap_max);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        take_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic wait_results_drained();
        while (epoch_expected_q.size() != 0) @(posedge aclk);
    endtask

    // Builds a random text: mostly well-formed timestamps, some plain byte noise.
    function automatic void build_random_text();
        int    kind;
        int    tail;
        int    cut;
        int    len;
        string s;
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
            s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d",
                          $urandom_range(0, 9999),
                          ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12)
                                                      : $urandom_range(0, 99),
                          ($urandom_range(0, 9) != 0) ? $urandom_range(1, 31)
                                                      : $urandom_range(0, 99),
                          ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23)
                                                      : $urandom_range(0, 99),
                          ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59)
                                                      : $urandom_range(0, 99),
                          ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59)
                                                      : $urandom_range(0, 99));
            tail = $urandom_range(0, 5);
            case (tail)
                1: s = {s, "Z"};
                2, 4: begin
                    s = {s, $sformatf("%c%02d:%02d", $urandom_range(0, 1) ? "+" : "-",
                                      $urandom_range(0, 99), $urandom_range(0, 99))};
                    if (tail == 4) s = {s, $sformatf("[%0d]", $urandom_range(0, 999))};
                end
                3: s = {s, $sformatf(".%0dZ", $urandom_range(0, 999999))};
                default: ;
            endcase
            load_text(s);
            if (tail == 5) begin
                cut = $urandom_range(1, 24);
                while (text_buf.size() > cut) void'(text_buf.pop_back());
            end
            // Sprinkle blanks, signs and stray bytes into the slots.
            foreach (text_buf[i]) begin
                if ($urandom_range(0, 19) == 0) begin
                    case ($urandom_range(0, 4))
                        0: text_buf[i] = ite_pkg::CH_SPACE;
                        1: text_buf[i] = 8'($urandom_range(9, 13));
                        2: text_buf[i] = ite_pkg::CH_PLUS;
                        3: text_buf[i] = ite_pkg::CH_MINUS;
                        default: text_buf[i] = 8'($urandom_range(0, 255));
                    endcase
                end
            end
        end else begin
            text_buf.delete();
            len = $urandom_range(1, 32);
            repeat (len) text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
        end
    endfunction

    // Result side: stall a random number of cycles before each result.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every accepted result against the oldest expected epoch.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (epoch_expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, $signed(m_tdata));
                err_count++;
            end else begin
                if (m_tdata !== epoch_expected_q[0]) begin
                    $display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
                             $time, $signed(epoch_expected_q[0]), $signed(m_tdata));
                    err_count++;
                end
                void'(epoch_expected_q.pop_front());
            end
            ready_hold = $urandom_range(0, stall_max);
        end
    end

    // Watchdog on cycles with no item taken on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic test_plain_timestamps();
        load_text("1970-01-01T00:00:00Z");
        send_text();
        load_text("0000-03-01T00:00:00");
        send_text();
        load_text("-999-01-01T00:00:00");
        send_text();
        load_text("9999-12-31T23:59:59");
        send_text();
    endtask

    task automatic test_length_edges();
        // Too short, a lone last character, past the limit of kept text, one short of full length.
        load_text("2021-06-15T08:30:0");
        send_text();
        load_text("Z");
        send_text();
        load_text("2000-01-01T12:00:00.123456Z");
        send_text();
        load_text("2021-06-15T08:30:00+01:0");
        send_text();
    endtask

    task automatic test_zone_offsets();
        load_text("2024-02-29T23:59:59+05:30");
        send_text();
        load_text("1969-12-31T23:59:59-08:00");
        send_text();
        load_text("9999-12-31T23:59:59+99:99");
        send_text();
        load_text("2001-09-09T01:46:40-ab: 7");
        send_text();
    endtask

    task automatic test_odd_fields();
        // Blanks and signs inside slots, a negative day that wraps.
        load_text(" +12- 3--9T 1:+2:-3");
        send_text();
        load_text("2020-00-00T00:00:00");
        send_text();
        load_text("2020--1-99T99:99:99");
        send_text();
        // Tab, LF, VT, FF and CR as leading blanks.
        load_text("\011\01212-\0131-\0141T\0151: 1:\0151");
        send_text();
        // A zero byte ends the month field.
        load_text("2020-1X-05T10:20:30");
        text_buf[6] = 8'h00;
        send_text();
        load_text("+x99-+-- 9T-+:+:+");
        send_text();
    endtask

    task automatic test_back_to_back();
        gap_max   = 0;
        stall_max = 0;
        load_text("2038-01-19T03:14:08+00:00");
        send_text();
        load_text("1900-02-28T12:00:00");
        send_text();
        load_text("12");
        send_text();
        gap_max   = 13;
        stall_max = 13;
    endtask

    task automatic test_random_texts();
        int target;
        int texts;
        target = chars_sent + RANDOM_ITEMS;
        texts  = 0;
        while (chars_sent < target) begin
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 13;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            build_random_text();
            send_text();
            texts++;
            // Now and then hold off until the pipeline has emptied.
            if (texts % 15 == 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait_results_drained();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_plain_timestamps();
        test_length_edges();
        test_zone_offsets();
        test_odd_fields();
        test_back_to_back();
        test_random_texts();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        wait_results_drained();
        repeat (PIPE_SETTLE) @(posedge aclk);

        if (err_count == 0 && epoch_expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            if (epoch_expected_q.size() != 0)
                $display("%0t: %0d expected results never arrived",
                         $time, epoch_expected_q.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
